// File: rtl/qwt_pkg.sv
// Package for the quality window read trimmer.
// Holds field widths, the read length limit and the configuration register codes.
// No dependencies; every other file in rtl/ imports it.
package qwt_pkg;

    localparam int READ_LEN_LIMIT = 4096;
    localparam int POS_W          = $clog2(READ_LEN_LIMIT);

    localparam int SCORE_W      = 8;
    localparam int WIN_W        = 8;
    localparam int THR_W        = 8;
    localparam int LEN_LIMIT_W  = 13;
    localparam int BOUND_W      = 12;
    localparam int TRIM_LEN_W   = 14;

    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SIZE     = 3'd0,
        CFG_LEFT_THRESHOLD  = 3'd1,
        CFG_RIGHT_THRESHOLD = 3'd2,
        CFG_MIN_LENGTH      = 3'd3,
        CFG_MAX_LENGTH      = 3'd4
    } cfg_index_t;

    localparam logic [WIN_W-1:0]       WINDOW_SIZE_RST     = 8'd10;
    localparam logic [THR_W-1:0]       LEFT_THRESHOLD_RST  = 8'd20;
    localparam logic [THR_W-1:0]       RIGHT_THRESHOLD_RST = 8'd20;
    localparam logic [LEN_LIMIT_W-1:0] MIN_LENGTH_RST      = 13'd0;
    localparam logic [LEN_LIMIT_W-1:0] MAX_LENGTH_RST      = 13'd4096;

endpackage

// File: rtl/qwt_if.sv
// Valid/ready channel interfaces of the quality window read trimmer.
// qwt_score_if carries one base score per item, qwt_result_if one read result.
// Depends on qwt_pkg for the field widths.
interface qwt_score_if
    import qwt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] score;
    logic               last_base;

    modport source (output valid, output score, output last_base, input ready);
    modport sink   (input valid, input score, input last_base, output ready);
endinterface

interface qwt_result_if
    import qwt_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic [BOUND_W-1:0]           left_bound;
    logic [BOUND_W-1:0]           right_bound;
    logic signed [TRIM_LEN_W-1:0] trimmed_length;
    logic                         right_found;
    logic                         keep;

    modport source (output valid, output left_bound, output right_bound,
                    output trimmed_length, output right_found, output keep,
                    input ready);
    modport sink   (input valid, input left_bound, input right_bound,
                    input trimmed_length, input right_found, input keep,
                    output ready);
endinterface

// File: rtl/quality_window_read_trimmer.sv
// Sliding window quality trimmer: one base score per item, one result per read.
// Depends on qwt_pkg and the channel interfaces in qwt_if.sv.
//
//   channel   dir   width                     item
//   scores    in    8 + 1                     score, last_base
//   results   out   12 + 12 + 14 + 1 + 1      left_bound .. keep
//   cfg       in    3 index + 13 data         one register write
//
// One item per cycle unless a stalled result holds a last base. Each item sits in
// the input register, is folded into the run counters and hit registers, and the
// read's result is written to the output register as its last base advances.
// Reset clears the per-read state and loads the register defaults.
// Only a last base waits on a stalled result; it then holds the input register,
// which backs up to scores.ready.
module quality_window_read_trimmer
    import qwt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    qwt_score_if.sink             scores,
    qwt_result_if.source          results
);

    // Configuration registers
    logic [WIN_W-1:0]       window_size_reg;
    logic [THR_W-1:0]       left_threshold_reg;
    logic [THR_W-1:0]       right_threshold_reg;
    logic [LEN_LIMIT_W-1:0] min_length_reg;
    logic [LEN_LIMIT_W-1:0] max_length_reg;

    // Input register
    logic               stage_valid_reg;
    logic [SCORE_W-1:0] stage_score_reg;
    logic               stage_last_reg;

    // Per-read state
    logic [POS_W-1:0] position_reg,        position_next;
    logic [WIN_W-1:0] left_run_reg,        left_run_next;
    logic [WIN_W-1:0] right_run_reg,       right_run_next;
    logic [POS_W-1:0] left_hit_end_reg,    left_hit_end_next;
    logic             left_hit_valid_reg,  left_hit_valid_next;
    logic [POS_W-1:0] right_hit_pos_reg,   right_hit_pos_next;
    logic             right_hit_valid_reg, right_hit_valid_next;

    // Output register
    logic                         out_valid_reg;
    logic [BOUND_W-1:0]           out_left_reg,  out_left_next;
    logic [BOUND_W-1:0]           out_right_reg, out_right_next;
    logic signed [TRIM_LEN_W-1:0] out_len_reg,   out_len_next;
    logic                         out_found_reg;
    logic                         out_keep_reg,  out_keep_next;

    logic                         advance;
    logic                         in_accept;
    logic [POS_W:0]               left_end_inc;
    logic [POS_W-1:0]             left_pos;
    logic [POS_W-1:0]             right_pos;
    logic [TRIM_LEN_W-1:0]        len_raw;
    logic signed [TRIM_LEN_W-1:0] min_len_s;
    logic signed [TRIM_LEN_W-1:0] max_len_s;

    // A base that does not end a read never touches the output register.
    assign advance   = stage_valid_reg && (!stage_last_reg || !out_valid_reg || results.ready);
    assign in_accept = scores.valid && scores.ready;
    assign scores.ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg     <= WINDOW_SIZE_RST;
            left_threshold_reg  <= LEFT_THRESHOLD_RST;
            right_threshold_reg <= RIGHT_THRESHOLD_RST;
            min_length_reg      <= MIN_LENGTH_RST;
            max_length_reg      <= MAX_LENGTH_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WINDOW_SIZE:     window_size_reg     <= cfg_data[WIN_W-1:0];
                CFG_LEFT_THRESHOLD:  left_threshold_reg  <= cfg_data[THR_W-1:0];
                CFG_RIGHT_THRESHOLD: right_threshold_reg <= cfg_data[THR_W-1:0];
                CFG_MIN_LENGTH:      min_length_reg      <= cfg_data[LEN_LIMIT_W-1:0];
                CFG_MAX_LENGTH:      max_length_reg      <= cfg_data[LEN_LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (scores.ready)
        begin
            stage_valid_reg <= scores.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_score_reg <= scores.score;
            stage_last_reg  <= scores.last_base;
        end
    end

    // Fold one score into the runs and hit registers.
    always_comb
    begin
        left_run_next  = '0;
        right_run_next = '0;
        if (stage_score_reg >= left_threshold_reg)
        begin
            left_run_next = (left_run_reg < window_size_reg) ?
                            left_run_reg + WIN_W'(1) : window_size_reg;
        end
        if (stage_score_reg >= right_threshold_reg)
        begin
            right_run_next = (right_run_reg < window_size_reg) ?
                             right_run_reg + WIN_W'(1) : window_size_reg;
        end

        left_hit_valid_next = left_hit_valid_reg;
        left_hit_end_next   = left_hit_end_reg;
        if (!left_hit_valid_reg && !stage_last_reg && left_run_next >= window_size_reg)
        begin
            left_hit_valid_next = 1'b1;
            left_hit_end_next   = position_reg;
        end

        right_hit_valid_next = right_hit_valid_reg;
        right_hit_pos_next   = right_hit_pos_reg;
        if (right_run_next >= window_size_reg && position_reg > POS_W'(window_size_reg))
        begin
            right_hit_valid_next = 1'b1;
            right_hit_pos_next   = position_reg;
        end

        position_next = position_reg;
        if (position_reg < POS_W'(READ_LEN_LIMIT - 1))
        begin
            position_next = position_reg + POS_W'(1);
        end
    end

    // Bounds and keep decision for the last base of a read.
    always_comb
    begin
        left_end_inc = {1'b0, left_hit_end_reg} + (POS_W+1)'(1);
        if (!left_hit_valid_reg)
        begin
            left_pos = position_reg;
        end
        else if (window_size_reg == '0 || left_end_inc < (POS_W+1)'(window_size_reg))
        begin
            left_pos = '0;
        end
        else
        begin
            left_pos = POS_W'(left_end_inc - (POS_W+1)'(window_size_reg));
        end

        right_pos = right_hit_valid_next ? right_hit_pos_next : position_reg;
        len_raw   = TRIM_LEN_W'(right_pos) + TRIM_LEN_W'(1) - TRIM_LEN_W'(left_pos);
        min_len_s = signed'(TRIM_LEN_W'(min_length_reg));
        max_len_s = signed'(TRIM_LEN_W'(max_length_reg));

        out_left_next  = BOUND_W'(left_pos);
        out_right_next = BOUND_W'(right_pos);
        out_len_next   = signed'(len_raw);
        out_keep_next  = right_hit_valid_next && (out_len_next >= min_len_s)
                         && (out_len_next <= max_len_s);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg        <= '0;
            left_run_reg        <= '0;
            right_run_reg       <= '0;
            left_hit_end_reg    <= '0;
            left_hit_valid_reg  <= 1'b0;
            right_hit_pos_reg   <= '0;
            right_hit_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (stage_last_reg)
            begin
                position_reg        <= '0;
                left_run_reg        <= '0;
                right_run_reg       <= '0;
                left_hit_end_reg    <= '0;
                left_hit_valid_reg  <= 1'b0;
                right_hit_pos_reg   <= '0;
                right_hit_valid_reg <= 1'b0;
            end
            else
            begin
                position_reg        <= position_next;
                left_run_reg        <= left_run_next;
                right_run_reg       <= right_run_next;
                left_hit_end_reg    <= left_hit_end_next;
                left_hit_valid_reg  <= left_hit_valid_next;
                right_hit_pos_reg   <= right_hit_pos_next;
                right_hit_valid_reg <= right_hit_valid_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && stage_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_last_reg)
        begin
            out_left_reg  <= out_left_next;
            out_right_reg <= out_right_next;
            out_len_reg   <= out_len_next;
            out_found_reg <= right_hit_valid_next;
            out_keep_reg  <= out_keep_next;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.left_bound     = out_left_reg;
    assign results.right_bound    = out_right_reg;
    assign results.trimmed_length = out_len_reg;
    assign results.right_found    = out_found_reg;
    assign results.keep           = out_keep_reg;

    // A finished read leaves the per-read state cleared.
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stage_last_reg) |=> (position_reg == '0 && !left_hit_valid_reg
                                         && !right_hit_valid_reg))
        else $error("per-read state not cleared after last base");

    // A stored hit never lies ahead of the current position.
    a_left_hit_behind: assert property (@(posedge clk) disable iff (!rst_n)
        left_hit_valid_reg |-> (left_hit_end_reg <= position_reg))
        else $error("left hit beyond current position");

    a_right_hit_behind: assert property (@(posedge clk) disable iff (!rst_n)
        right_hit_valid_reg |-> (right_hit_pos_reg <= position_reg))
        else $error("right hit beyond current position");

    // Keep is only granted when a right window was found.
    a_keep_needs_right: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.keep) |-> results.right_found)
        else $error("keep without right window");

    // A registered base is never dropped while the output stalls.
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !advance) |=> stage_valid_reg)
        else $error("registered base lost during stall");

endmodule
